// ===== rtl/itf_pkg.sv =====
// ----------------------------------------------------------------------------
// itf_pkg
// Shared types, field widths and character codes for the integer text
// formatter and its divide unit.
// ----------------------------------------------------------------------------
package itf_pkg;

  // payload field widths
  localparam int VALUE_W  = 64;
  localparam int RADIX_W  = 5;
  localparam int FLAGS_W  = 7;
  localparam int FIELD_W  = 6;
  localparam int CHAR_W   = 8;
  localparam int COUNT_W  = 6;
  localparam int DIGIT_W  = 4;

  // packed bus widths
  localparam int S_DATA_W = 96;
  localparam int M_DATA_W = 16;

  // position counters inside one formatted field
  localparam int POS_W    = 7;

  // quotient bits retired by the divide unit per cycle
  localparam int STEP_BITS = 8;

  // base limits
  localparam logic [RADIX_W-1:0] RADIX_MIN = 5'd8;
  localparam logic [RADIX_W-1:0] RADIX_MAX = 5'd16;

  // flag bit positions
  localparam int FLAG_SIGNED = 0;
  localparam int FLAG_UPPER  = 1;
  localparam int FLAG_PLUS   = 2;
  localparam int FLAG_SPACE  = 3;
  localparam int FLAG_ALT    = 4;
  localparam int FLAG_LEFT   = 5;
  localparam int FLAG_ZERO   = 6;

  // ascii codes
  localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2b;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2d;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_UA    = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UX    = 8'h58;
  localparam logic [CHAR_W-1:0] CH_LA    = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LX    = 8'h78;

  typedef logic [POS_W-1:0] pos_t;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_CHECK = 5'b00010,
    ST_DIV   = 5'b00100,
    ST_SETUP = 5'b01000,
    ST_EMIT  = 5'b10000
  } state_t;

  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d,
                                                   input logic upper);
    logic [CHAR_W-1:0] base_ch;
    base_ch = upper ? CH_UA : CH_LA;
    if (d < 4'd10) begin
      digit_char = CH_ZERO + CHAR_W'(d);
    end else begin
      digit_char = base_ch + CHAR_W'(d) - CHAR_W'(10);
    end
  endfunction

endpackage

// ===== rtl/itf_divider.sv =====
// ----------------------------------------------------------------------------
// itf_divider
// Iterative divide of a 64-bit value by a small base; restoring long
// division retiring several quotient bits per cycle.
// ----------------------------------------------------------------------------
module itf_divider (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [itf_pkg::VALUE_W-1:0]  dividend,
  input  logic [itf_pkg::RADIX_W-1:0]  divisor,
  output logic                         done,
  output logic [itf_pkg::VALUE_W-1:0]  quotient,
  output logic [itf_pkg::DIGIT_W-1:0]  remainder
);
  import itf_pkg::*;

  localparam int PASSES = VALUE_W / STEP_BITS;
  localparam int CNT_W  = $clog2(PASSES);

  logic                 running;
  logic [CNT_W-1:0]     cnt;
  logic [VALUE_W-1:0]   work;
  logic [DIGIT_W-1:0]   rem;
  logic [STEP_BITS-1:0] q_bits;
  logic [DIGIT_W-1:0]   rem_next;

  // one compare and subtract per quotient bit, msb first
  always_comb begin
    logic [RADIX_W-1:0] trial;
    rem_next = rem;
    q_bits   = '0;
    for (int i = 0; i < STEP_BITS; i++) begin
      trial = {rem_next, work[VALUE_W-1-i]};
      if (trial >= divisor) begin
        trial = trial - divisor;
        q_bits[STEP_BITS-1-i] = 1'b1;
      end
      rem_next = trial[DIGIT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        cnt     <= '0;
      end else if (running) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(PASSES - 1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      work <= dividend;
      rem  <= '0;
    end else if (running) begin
      work <= {work[VALUE_W-STEP_BITS-1:0], q_bits};
      rem  <= rem_next;
    end
  end

  assign quotient  = work;
  assign remainder = rem;

endmodule

// ===== rtl/integer_text_formatter.sv =====
// ----------------------------------------------------------------------------
// integer_text_formatter
// Formats one 64-bit integer as printf-style text, one character per
// output transfer.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream (s_*): one transfer carries the value, base, flags, width
//   and precision. s_tready is high only while the block is idle; it stays
//   low from the accepted transfer until the last character is loaded.
//   Output stream (m_*): one transfer per character, m_tlast on the final
//   one, m_tuser high for a real character. Empty text gives one transfer
//   with m_tuser low and m_tlast high.
//   The digits come from the divide unit, which retires 8 quotient bits a
//   cycle; each digit takes a divide pass, a result step and a check. All
//   digits are produced before the first character, then one character
//   goes out per cycle while the receiver keeps up; up to 22 digits and
//   43 characters.
//   The output register lets the next item be accepted while the final
//   character still waits to be taken. A stalled receiver holds the
//   character in place and pauses the emission; nothing is dropped.
//   Reset clears the sequencer and the output valid; the block comes up idle.
// ----------------------------------------------------------------------------
module integer_text_formatter #(
  parameter int MAX_FIELD   = 40,
  parameter int DIGIT_STORE = 22
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // value[63:0], base[68:64], flags[75:69], width_given[76],
  // field_width[82:77], precision_given[83], precision[89:84], zeros above
  input  logic [itf_pkg::S_DATA_W-1:0]  s_tdata,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // character[7:0], char_count[13:8], zeros above
  output logic [itf_pkg::M_DATA_W-1:0]  m_tdata,
  output logic                          m_tlast,
  // char_valid[0]
  output logic                          m_tuser
);
  import itf_pkg::*;

  localparam int ADDR_W = (DIGIT_STORE > 1) ? $clog2(DIGIT_STORE) : 1;
  localparam int NUM_W  = $clog2(DIGIT_STORE + 1);

  // input field unpacking
  logic [VALUE_W-1:0] in_value;
  logic [RADIX_W-1:0] in_base;
  logic [FLAGS_W-1:0] in_flags;
  logic               in_wgiven;
  logic [FIELD_W-1:0] in_width;
  logic               in_pgiven;
  logic [FIELD_W-1:0] in_prec;

  assign in_value  = s_tdata[63:0];
  assign in_base   = s_tdata[68:64];
  assign in_flags  = s_tdata[75:69];
  assign in_wgiven = s_tdata[76];
  assign in_width  = s_tdata[82:77];
  assign in_pgiven = s_tdata[83];
  assign in_prec   = s_tdata[89:84];

  state_t             state;
  logic [VALUE_W-1:0] val;
  logic [RADIX_W-1:0] base;
  logic               upper, plus, space, alt, left, zero, neg, vnz;
  logic               wgiven, pgiven;
  logic [FIELD_W-1:0] width, prec;
  logic [NUM_W-1:0]   nd;
  logic [NUM_W-1:0]   dptr;
  logic [NUM_W-1:0]   dptr_next;
  logic [ADDR_W-1:0]  rd_addr;
  logic [DIGIT_W-1:0] rd_data;
  logic [DIGIT_W-1:0] digit_mem [DIGIT_STORE];
  pos_t               b0, b1, b2, b3, b4, total, k;

  logic [CHAR_W-1:0]  out_char;
  logic [COUNT_W-1:0] out_count;
  logic               out_cv, out_last;

  // divide unit
  logic               div_start, div_done;
  logic [VALUE_W-1:0] div_quot;
  logic [DIGIT_W-1:0] div_rem;

  logic               accept, digits_done, advance, is_digit, mem_we;
  logic [RADIX_W-1:0] base_clamped;
  logic [FIELD_W-1:0] width_sat, prec_sat;
  logic [CHAR_W-1:0]  char_sel;
  pos_t               k_inc;

  // field layout computed in the setup cycle
  pos_t nd_pos, prec_base, prec_eff, size, pad, lead, zeros, trail;
  logic sign_len, zfill;
  pos_t pfx_len;

  assign s_tready    = (state == ST_IDLE);
  assign accept      = s_tvalid && s_tready;
  assign digits_done = (val == '0) || (nd == NUM_W'(DIGIT_STORE));
  assign div_start   = (state == ST_CHECK) && !digits_done;
  assign mem_we      = (state == ST_DIV) && div_done;
  assign advance     = !m_tvalid || m_tready;
  assign k_inc       = k + 1'b1;
  assign is_digit    = (k >= b3) && (k < b4);

  always_comb begin
    if (in_base < RADIX_MIN) begin
      base_clamped = RADIX_MIN;
    end else if (in_base > RADIX_MAX) begin
      base_clamped = RADIX_MAX;
    end else begin
      base_clamped = in_base;
    end
    width_sat = (in_width > FIELD_W'(MAX_FIELD)) ? FIELD_W'(MAX_FIELD) : in_width;
    prec_sat  = (in_prec > FIELD_W'(MAX_FIELD)) ? FIELD_W'(MAX_FIELD) : in_prec;
  end

  itf_divider u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (val),
    .divisor   (base),
    .done      (div_done),
    .quotient  (div_quot),
    .remainder (div_rem)
  );

  // layout: lead spaces, sign, prefix, zeros, digits, trailing spaces
  always_comb begin
    nd_pos    = POS_W'(nd);
    prec_base = pgiven ? POS_W'(prec) : POS_W'(1);
    prec_eff  = (prec_base < nd_pos) ? nd_pos : prec_base;
    sign_len  = neg || plus || space;
    if (vnz && alt && base == RADIX_MAX) begin
      pfx_len = POS_W'(2);
    end else if (vnz && alt && base == RADIX_MIN) begin
      pfx_len = POS_W'(1);
    end else begin
      pfx_len = '0;
    end
    size  = prec_eff + POS_W'(sign_len) + pfx_len;
    pad   = (wgiven && size < POS_W'(width)) ? POS_W'(width) - size : '0;
    zfill = !left && zero;
    lead  = (left || zfill) ? '0 : pad;
    zeros = prec_eff - nd_pos + (zfill ? pad : '0);
    trail = left ? pad : '0;
  end

  // character at position k
  always_comb begin
    priority if (k < b0) begin
      char_sel = CH_SPACE;
    end else if (k < b1) begin
      char_sel = neg ? CH_MINUS : (plus ? CH_PLUS : CH_SPACE);
    end else if (k < b2) begin
      char_sel = (k == b1) ? CH_ZERO : (upper ? CH_UX : CH_LX);
    end else if (k < b3) begin
      char_sel = CH_ZERO;
    end else if (k < b4) begin
      char_sel = digit_char(rd_data, upper);
    end else begin
      char_sel = CH_SPACE;
    end
  end

  // digits leave most significant first; read port is pointed one step ahead
  always_comb begin
    dptr_next = dptr;
    if (state == ST_SETUP) begin
      dptr_next = nd;
    end else if (state == ST_EMIT && advance && total != '0 && is_digit) begin
      dptr_next = dptr - 1'b1;
    end
    rd_addr = (dptr_next == '0) ? '0 : ADDR_W'(dptr_next - 1'b1);
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      digit_mem[nd[ADDR_W-1:0]] <= div_rem;
    end
    rd_data <= digit_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      if (state == ST_EMIT && advance) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            state <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          state <= digits_done ? ST_SETUP : ST_DIV;
        end
        ST_DIV: begin
          if (div_done) begin
            state <= ST_CHECK;
          end
        end
        ST_SETUP: begin
          state <= ST_EMIT;
        end
        ST_EMIT: begin
          if (advance) begin
            if (total == '0 || k_inc == total) begin
              state <= ST_IDLE;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    dptr <= dptr_next;
    if (accept) begin
      val    <= (in_flags[FLAG_SIGNED] && in_value[VALUE_W-1]) ? '0 - in_value : in_value;
      neg    <= in_flags[FLAG_SIGNED] && in_value[VALUE_W-1];
      vnz    <= (in_value != '0);
      base   <= base_clamped;
      upper  <= in_flags[FLAG_UPPER];
      plus   <= in_flags[FLAG_PLUS];
      space  <= in_flags[FLAG_SPACE];
      alt    <= in_flags[FLAG_ALT];
      left   <= in_flags[FLAG_LEFT];
      zero   <= in_flags[FLAG_ZERO];
      wgiven <= in_wgiven;
      width  <= width_sat;
      pgiven <= in_pgiven;
      prec   <= prec_sat;
      nd     <= '0;
    end
    if (mem_we) begin
      val <= div_quot;
      nd  <= nd + 1'b1;
    end
    if (state == ST_SETUP) begin
      b0    <= lead;
      b1    <= lead + POS_W'(sign_len);
      b2    <= lead + POS_W'(sign_len) + pfx_len;
      b3    <= lead + POS_W'(sign_len) + pfx_len + zeros;
      b4    <= lead + POS_W'(sign_len) + pfx_len + zeros + nd_pos;
      total <= lead + POS_W'(sign_len) + pfx_len + zeros + nd_pos + trail;
      k     <= '0;
    end
    if (state == ST_EMIT && advance) begin
      if (total == '0) begin
        // empty text: one marker transfer with no character
        out_char  <= CH_NUL;
        out_cv    <= 1'b0;
        out_last  <= 1'b1;
        out_count <= '0;
      end else begin
        out_char  <= char_sel;
        out_cv    <= 1'b1;
        out_last  <= (k_inc == total);
        out_count <= k_inc[COUNT_W-1:0];
        k         <= k_inc;
      end
    end
  end

  assign m_tdata = {{(M_DATA_W - CHAR_W - COUNT_W){1'b0}}, out_count, out_char};
  assign m_tlast = out_last;
  assign m_tuser = out_cv;

endmodule

// ===== rtl/itf_checker.sv =====
// ----------------------------------------------------------------------------
// itf_checker
// Port-level checks for the integer text formatter, bound to the top level.
// ----------------------------------------------------------------------------
module itf_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         s_tvalid,
  input logic                         s_tready,
  input logic                         m_tvalid,
  input logic                         m_tready,
  input logic [itf_pkg::M_DATA_W-1:0] m_tdata,
  input logic                         m_tlast,
  input logic                         m_tuser
);
  import itf_pkg::*;

  // a stalled character holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
      && $stable(m_tuser))
    else $error("output changed while stalled");

  // empty text marker is a lone final transfer with zero count
  a_empty: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tlast && (m_tdata[CHAR_W +: COUNT_W] == '0))
    else $error("empty marker malformed");

  // a real character always has a nonzero running count
  a_count: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> (m_tdata[CHAR_W +: COUNT_W] != '0))
    else $error("character with zero count");

  // no new item is taken while the current one is still being emitted
  a_busy: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> !s_tready)
    else $error("ready while emitting");

  // one item at a time
  a_one: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("ready right after input transfer");

endmodule

bind integer_text_formatter itf_checker u_itf_checker (.*);

// ===== dv/itf_text_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// itf_text_checker
// Watches both streams of the integer text formatter. Every accepted input
// transfer is formatted here into the characters it must produce. Each output
// transfer is compared with the oldest character still due.
// ----------------------------------------------------------------------------
module itf_text_checker #(
  parameter int MAX_FIELD   = 40,
  parameter int DIGIT_STORE = 22
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  input  logic                         s_tready,
  input  logic [itf_pkg::S_DATA_W-1:0] s_tdata,
  input  logic                         m_tvalid,
  input  logic                         m_tready,
  input  logic [itf_pkg::M_DATA_W-1:0] m_tdata,
  input  logic                         m_tlast,
  input  logic                         m_tuser,
  output int                           fail_count,
  output int                           chars_due,
  output int                           items_taken,
  output int                           chars_taken,
  output int                           empty_taken
);
  import itf_pkg::*;

  typedef struct packed {
    logic [CHAR_W-1:0]  ch;
    logic               valid;
    logic               last;
    logic [COUNT_W-1:0] count;
  } text_char_t;

  text_char_t due_q[$];
  int         n_fail = 0;
  int         n_items = 0;
  int         n_chars = 0;
  int         n_empty = 0;

  // builds the printf-style text of one request and queues its characters
  function automatic void format_value(input logic [VALUE_W-1:0] raw,
                                       input logic [RADIX_W-1:0] radix_in,
                                       input logic [FLAGS_W-1:0] fl,
                                       input logic               wgiven,
                                       input logic [FIELD_W-1:0] fwidth,
                                       input logic               pgiven,
                                       input logic [FIELD_W-1:0] prec_in);
    string              glyphs;
    logic [VALUE_W-1:0] mag;
    logic [VALUE_W-1:0] rest;
    logic [VALUE_W-1:0] radix;
    logic               neg;
    logic               signch;
    int                 width_lim;
    int                 min_digits;
    int                 nd;
    int                 pad;
    int                 prefix;
    int                 total;
    int                 idx;
    logic [CHAR_W-1:0]  digs[$];
    logic [CHAR_W-1:0]  text[$];
    text_char_t         c;

    glyphs = "0123456789abcdef0123456789ABCDEF";
    radix  = (radix_in < RADIX_MIN) ? VALUE_W'(RADIX_MIN) :
             (radix_in > RADIX_MAX) ? VALUE_W'(RADIX_MAX) : VALUE_W'(radix_in);
    width_lim = (fwidth > MAX_FIELD) ? MAX_FIELD : int'(fwidth);
    min_digits = (prec_in > MAX_FIELD) ? MAX_FIELD : int'(prec_in);

    neg = fl[FLAG_SIGNED] && raw[VALUE_W-1];
    mag = neg ? -raw : raw;

    // digits come out least significant first
    rest = mag;
    nd = 0;
    while (rest != '0 && nd < DIGIT_STORE) begin
      idx = int'(rest % radix) + (fl[FLAG_UPPER] ? 16 : 0);
      digs.push_back(glyphs[idx]);
      rest = rest / radix;
      nd++;
    end

    if (!pgiven) min_digits = 1;
    if (min_digits < nd) min_digits = nd;
    signch = neg || fl[FLAG_PLUS] || fl[FLAG_SPACE];
    prefix = 0;
    if (mag != '0 && fl[FLAG_ALT]) begin
      if (radix == 16) prefix = 2;
      else if (radix == 8) prefix = 1;
    end
    total = min_digits + prefix + (signch ? 1 : 0);
    pad = (wgiven && total < width_lim) ? width_lim - total : 0;
    if (!fl[FLAG_LEFT] && fl[FLAG_ZERO]) begin
      min_digits += pad;
      pad = 0;
    end

    if (!fl[FLAG_LEFT]) repeat (pad) text.push_back(CH_SPACE);
    if (neg) text.push_back(CH_MINUS);
    else if (fl[FLAG_PLUS]) text.push_back(CH_PLUS);
    else if (fl[FLAG_SPACE]) text.push_back(CH_SPACE);
    if (prefix > 0) text.push_back(CH_ZERO);
    if (prefix > 1) text.push_back(fl[FLAG_UPPER] ? CH_UX : CH_LX);
    repeat (min_digits - nd) text.push_back(CH_ZERO);
    for (int i = nd - 1; i >= 0; i--) text.push_back(digs[i]);
    if (fl[FLAG_LEFT]) repeat (pad) text.push_back(CH_SPACE);

    if (text.size() == 0) begin
      c = '{ch: CH_NUL, valid: 1'b0, last: 1'b1, count: '0};
      due_q.push_back(c);
    end else begin
      foreach (text[i]) begin
        c.ch    = text[i];
        c.valid = 1'b1;
        c.last  = (i == text.size() - 1);
        c.count = COUNT_W'(i + 1);
        due_q.push_back(c);
      end
    end
  endfunction

  always @(posedge clk) begin
    text_char_t want;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        format_value(s_tdata[63:0], s_tdata[68:64], s_tdata[75:69], s_tdata[76],
                     s_tdata[82:77], s_tdata[83], s_tdata[89:84]);
        n_items++;
      end
      if (m_tvalid && m_tready) begin
        if (due_q.size() == 0) begin
          n_fail++;
          $error("output transfer with nothing due: character %h count %0d last %b",
                 m_tdata[7:0], m_tdata[13:8], m_tlast);
        end else begin
          want = due_q.pop_front();
          if (m_tdata[7:0] !== want.ch) begin
            n_fail++;
            $error("character: expected %h, actual %h", want.ch, m_tdata[7:0]);
          end
          if (m_tuser !== want.valid) begin
            n_fail++;
            $error("char_valid: expected %b, actual %b", want.valid, m_tuser);
          end
          if (m_tlast !== want.last) begin
            n_fail++;
            $error("last: expected %b, actual %b", want.last, m_tlast);
          end
          if (m_tdata[13:8] !== want.count) begin
            n_fail++;
            $error("char_count: expected %0d, actual %0d", want.count, m_tdata[13:8]);
          end
          if (want.valid) n_chars++;
          else n_empty++;
        end
      end
    end
    fail_count  <= n_fail;
    chars_due   <= due_q.size();
    items_taken <= n_items;
    chars_taken <= n_chars;
    empty_taken <= n_empty;
  end

endmodule

// ===== dv/tb_integer_text_formatter.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_integer_text_formatter
// Drives format requests into the integer text formatter: a directed set
// covering field extremes, sign, prefix, padding and the empty text, then
// random requests sent in bursts while the receiver stalls on its own
// pattern, including one long hold-off that backs up the input.
// ----------------------------------------------------------------------------
module tb_integer_text_formatter;
  import itf_pkg::*;

  localparam int RANDOM_ITEMS = 320;
  localparam int LONG_HOLD    = 400;
  localparam int TAIL_CYCLES  = 300;

  typedef enum int { SINK_OPEN, SINK_LIGHT, SINK_HALF, SINK_HEAVY } sink_mode_t;

  logic                clk;
  logic                rst      = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [S_DATA_W-1:0] s_tdata  = '0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [M_DATA_W-1:0] m_tdata;
  logic                m_tlast;
  logic                m_tuser;

  int fail_total;
  int chars_due;
  int items_taken;
  int chars_taken;
  int empty_taken;
  int burst_left = 0;

  integer_text_formatter dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  itf_text_checker checker_i (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tlast     (m_tlast),
    .m_tuser     (m_tuser),
    .fail_count  (fail_total),
    .chars_due   (chars_due),
    .items_taken (items_taken),
    .chars_taken (chars_taken),
    .empty_taken (empty_taken)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // ends the run as a failure if the formatter stops making progress
  initial begin
    #12_000_000;
    $display("timeout: formatter stopped making progress");
    $display("status: fail");
    $finish;
  end

  // one request transfer, then either stay valid for the next or leave a gap
  task automatic send_request(input logic [VALUE_W-1:0] v, input logic [RADIX_W-1:0] b,
                              input logic [FLAGS_W-1:0] f, input logic wg,
                              input logic [FIELD_W-1:0] fw, input logic pg,
                              input logic [FIELD_W-1:0] p);
    s_tdata  <= {6'b0, p, pg, fw, wg, f, b, v};
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = $urandom_range(0, 8);
    end
  endtask

  task automatic send_random();
    logic [VALUE_W-1:0] v;
    logic [RADIX_W-1:0] b;
    logic [FIELD_W-1:0] fw;
    logic [FIELD_W-1:0] p;
    case ($urandom_range(0, 9))
      0: v = '0;
      1: v = VALUE_W'($urandom_range(0, 15));
      2, 3: v = VALUE_W'($urandom_range(0, 65535));
      4: v = -VALUE_W'($urandom_range(1, 1000));
      5: v = {$urandom, $urandom} >> $urandom_range(0, 63);
      6: case ($urandom_range(0, 3))
           0: v = '1;
           1: v = {1'b1, 63'b0};
           2: v = {1'b0, {63{1'b1}}};
           default: v = 64'd1;
         endcase
      default: v = {$urandom, $urandom};
    endcase
    case ($urandom_range(0, 9))
      0, 1, 2: b = 5'd8;
      3, 4, 5: b = 5'd10;
      6, 7: b = 5'd16;
      default: b = RADIX_W'($urandom_range(0, 31));
    endcase
    fw = ($urandom_range(0, 6) == 0) ? FIELD_W'($urandom_range(0, 63))
                                     : FIELD_W'($urandom_range(0, 24));
    case ($urandom_range(0, 6))
      0, 1, 2: p = FIELD_W'($urandom_range(0, 2));
      3: p = FIELD_W'($urandom_range(0, 63));
      default: p = FIELD_W'($urandom_range(0, 24));
    endcase
    send_request(v, b, FLAGS_W'($urandom_range(0, 127)), 1'($urandom_range(0, 1)), fw,
                 1'($urandom_range(0, 1)), p);
  endtask

  // receiver: random ready patterns, plus one long hold once traffic runs
  initial begin : sink
    sink_mode_t mode;
    int         run;
    bit         held;
    held = 1'b0;
    while (rst) @(posedge clk);
    forever begin
      if (!held && items_taken >= 40) begin
        held = 1'b1;
        m_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end
      mode = sink_mode_t'($urandom_range(0, 3));
      run  = $urandom_range(4, 60);
      repeat (run) begin
        case (mode)
          SINK_OPEN:  m_tready <= 1'b1;
          SINK_LIGHT: m_tready <= ($urandom_range(0, 3) != 0);
          SINK_HALF:  m_tready <= 1'($urandom_range(0, 1));
          default:    m_tready <= ($urandom_range(0, 3) == 0);
        endcase
        @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // flags: {zero, left, alt, space, plus, upper, signed}
    send_request(64'd0, 5'd10, 7'h00, 1'b0, 6'd0, 1'b0, 6'd0);      // default precision
    send_request(64'd0, 5'd10, 7'h00, 1'b0, 6'd0, 1'b1, 6'd0);      // empty text
    send_request(64'd0, 5'd10, 7'h04, 1'b0, 6'd0, 1'b1, 6'd0);      // sign only
    send_request(64'd0, 5'd10, 7'h00, 1'b1, 6'd5, 1'b1, 6'd0);      // padding only
    send_request('1, 5'd10, 7'h00, 1'b0, 6'd0, 1'b0, 6'd0);
    send_request('1, 5'd8, 7'h10, 1'b0, 6'd0, 1'b0, 6'd0);          // 22 digits plus prefix
    send_request({1'b1, 63'b0}, 5'd10, 7'h01, 1'b0, 6'd0, 1'b0, 6'd0);
    send_request('1, 5'd10, 7'h0D, 1'b0, 6'd0, 1'b0, 6'd0);         // minus beats plus
    send_request(64'd255, 5'd16, 7'h12, 1'b0, 6'd0, 1'b0, 6'd0);
    send_request(64'd255, 5'd16, 7'h50, 1'b1, 6'd10, 1'b0, 6'd0);
    send_request(64'd42, 5'd10, 7'h0C, 1'b0, 6'd0, 1'b0, 6'd0);      // plus beats space
    send_request(64'd42, 5'd10, 7'h08, 1'b0, 6'd0, 1'b0, 6'd0);
    send_request(64'd42, 5'd10, 7'h20, 1'b1, 6'd8, 1'b0, 6'd0);
    send_request(64'd42, 5'd10, 7'h60, 1'b1, 6'd8, 1'b0, 6'd0);      // left overrides zero
    send_request(64'd7, 5'd8, 7'h10, 1'b0, 6'd0, 1'b1, 6'd3);        // octal prefix on top
    send_request(64'd0, 5'd16, 7'h10, 1'b0, 6'd0, 1'b0, 6'd0);       // no prefix for zero
    send_request(64'd100, 5'd3, 7'h10, 1'b0, 6'd0, 1'b0, 6'd0);      // base clamps up
    send_request(64'd100, 5'd31, 7'h12, 1'b0, 6'd0, 1'b0, 6'd0);     // base clamps down
    send_request(64'd1234567, 5'd12, 7'h12, 1'b0, 6'd0, 1'b0, 6'd0); // odd base, no prefix
    send_request(64'd1, 5'd16, 7'h14, 1'b1, 6'd63, 1'b1, 6'd63);     // saturated, 43 chars
    send_request(64'd5, 5'd10, 7'h40, 1'b1, 6'd6, 1'b1, 6'd2);       // zero with precision
    send_request(64'd5, 5'd10, 7'h00, 1'b0, 6'd20, 1'b0, 6'd0);      // width not given
    send_request(64'hfedc_ba98_7654_3210, 5'd16, 7'h7F, 1'b1, 6'd33, 1'b1, 6'd9);

    repeat (RANDOM_ITEMS) send_random();

    s_tvalid <= 1'b0;
    @(posedge clk);
    while (chars_due != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d requests: %0d characters and %0d empty texts checked",
             items_taken, chars_taken, empty_taken);
    $display("mismatches found: %0d", fail_total);
    if (fail_total == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/itf_pkg.sv
rtl/itf_divider.sv
rtl/integer_text_formatter.sv
rtl/itf_checker.sv
dv/itf_text_checker.sv
dv/tb_integer_text_formatter.sv
